FILE: hdl/pcb_pkg.sv
// shared types, constants and lane helpers for the configuration space bridge
// no dependencies; used by pcb_hdr and pci_config_space_bridge
`default_nettype none

package pcb_pkg;

  typedef enum logic [1:0] {
    REQ_ADDR_RD = 2'd0,
    REQ_ADDR_WR = 2'd1,
    REQ_DATA_RD = 2'd2,
    REQ_DATA_WR = 2'd3
  } req_t;

  // configuration register indexes
  localparam logic [1:0] CFG_BAR_BASE = 2'd0;
  localparam logic [1:0] CFG_TGT_DEV  = 2'd1;
  localparam logic [1:0] CFG_TGT_FN   = 2'd2;

  // header dword indexes (latch bits 7:2)
  localparam logic [5:0] HDR_IDX_IDS    = 6'h00;
  localparam logic [5:0] HDR_IDX_CMD    = 6'h01;
  localparam logic [5:0] HDR_IDX_CLASS  = 6'h02;
  localparam logic [5:0] HDR_IDX_CACHE  = 6'h03;
  localparam logic [5:0] HDR_IDX_BAR0   = 6'h04;
  localparam logic [5:0] HDR_IDX_SUBSYS = 6'h0b;
  localparam logic [5:0] HDR_IDX_INTR   = 6'h0f;

  localparam logic [15:0] VENDOR_ID     = 16'h1033;
  localparam logic [15:0] DEVICE_ID     = 16'h0035;
  localparam logic [15:0] STATUS_WORD   = 16'h0210;
  localparam logic [23:0] CLASS_CODE    = 24'h0c0310;
  localparam logic [7:0]  REVISION_ID   = 8'h10;
  localparam logic [7:0]  INTR_PIN_INTA = 8'h01;
  localparam logic [7:0]  INTR_LINE_RST = 8'hff;
  localparam logic [31:0] ALL_ONES      = 32'hffff_ffff;
  localparam int unsigned LATCH_ENABLE_BIT = 31;

  typedef struct packed {
    logic        en;
    logic [5:0]  idx;
    logic [31:0] data;
    logic [31:0] mask;
  } hdr_wr_t;

  // access_size bytes, sizes above four clamp to a full dword
  function automatic logic [31:0] size_mask(input logic [2:0] size);
    logic [31:0] m;
    unique case (size)
      3'd0:    m = 32'h0000_0000;
      3'd1:    m = 32'h0000_00ff;
      3'd2:    m = 32'h0000_ffff;
      3'd3:    m = 32'h00ff_ffff;
      default: m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

  // lanes touched, clipped to the dword
  function automatic logic [31:0] lane_mask(input logic [1:0] off, input logic [2:0] size);
    return size_mask(size) << {off, 3'b000};
  endfunction

endpackage

`default_nettype wire

FILE: hdl/pcb_hdr.sv
// configuration header of the emulated function: writable fields and read mux
// depends on pcb_pkg
`default_nettype none

module pcb_hdr #(
  parameter int unsigned BAR_SIZE_LOG2 = 12
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic [31:0]     bar_base,
  input  wire logic [5:0]      rd_idx,
  output logic      [31:0]     rd_data,
  input  wire pcb_pkg::hdr_wr_t wr
);

  localparam logic [31:0] BAR_PROBE_VALUE = pcb_pkg::ALL_ONES << BAR_SIZE_LOG2;

  logic [15:0] command_r, command_nxt;
  logic [7:0]  cache_line_r, cache_line_nxt;
  logic [7:0]  latency_r, latency_nxt;
  logic [7:0]  intr_line_r, intr_line_nxt;
  logic        bar_probe_r, bar_probe_nxt;

  always_comb begin
    command_nxt    = command_r;
    cache_line_nxt = cache_line_r;
    latency_nxt    = latency_r;
    intr_line_nxt  = intr_line_r;
    bar_probe_nxt  = bar_probe_r;
    if (wr.en) begin
      unique case (wr.idx)
        pcb_pkg::HDR_IDX_CMD: begin
          command_nxt = (command_r & ~wr.mask[15:0]) | (wr.data[15:0] & wr.mask[15:0]);
        end
        pcb_pkg::HDR_IDX_CACHE: begin
          if (|wr.mask[7:0]) cache_line_nxt = wr.data[7:0];
          if (|wr.mask[15:8]) latency_nxt = wr.data[15:8];
        end
        // all written lanes 0xff enter size probe, anything else returns the base
        pcb_pkg::HDR_IDX_BAR0: bar_probe_nxt = &(wr.data | ~wr.mask);
        pcb_pkg::HDR_IDX_INTR: begin
          if (|wr.mask[7:0]) intr_line_nxt = wr.data[7:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      command_r    <= '0;
      cache_line_r <= '0;
      latency_r    <= '0;
      intr_line_r  <= pcb_pkg::INTR_LINE_RST;
      bar_probe_r  <= 1'b0;
    end else begin
      command_r    <= command_nxt;
      cache_line_r <= cache_line_nxt;
      latency_r    <= latency_nxt;
      intr_line_r  <= intr_line_nxt;
      bar_probe_r  <= bar_probe_nxt;
    end
  end

  always_comb begin
    unique case (rd_idx)
      pcb_pkg::HDR_IDX_IDS,
      pcb_pkg::HDR_IDX_SUBSYS: rd_data = {pcb_pkg::DEVICE_ID, pcb_pkg::VENDOR_ID};
      pcb_pkg::HDR_IDX_CMD:    rd_data = {pcb_pkg::STATUS_WORD, command_r};
      pcb_pkg::HDR_IDX_CLASS:  rd_data = {pcb_pkg::CLASS_CODE, pcb_pkg::REVISION_ID};
      pcb_pkg::HDR_IDX_CACHE:  rd_data = {16'h0000, latency_r, cache_line_r};
      pcb_pkg::HDR_IDX_BAR0:   rd_data = bar_probe_r ? BAR_PROBE_VALUE : bar_base;
      pcb_pkg::HDR_IDX_INTR:   rd_data = {16'h0000, pcb_pkg::INTR_PIN_INTA, intr_line_r};
      default:                 rd_data = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/pci_config_space_bridge.sv
// top level: address latch, bus-0 decode, input and result registers
// depends on pcb_pkg and pcb_hdr
`default_nettype none

// Host bridge configuration access, mechanism #1 style. Address-port beats
// read or merge byte lanes of a 32-bit latch; data-port beats reach one
// emulated function's header when latch bit 31 is set, the bus is 0 and
// device/function match the configured target, else reads give all ones
// and writes are dropped. Every beat returns one result (zero for writes).
// Throughput is one beat per cycle unless a held result stalls intake; a
// beat passes the input register, then the result register, with the
// decode, lane shift and header update done in a single pass between. Both
// stages advance independently, so a held result does not block intake
// until both registers are full. Configuration writes are taken at once
// and must only be issued while no beat is in flight.
module pci_config_space_bridge #(
  parameter int unsigned BAR_SIZE_LOG2 = 12
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [1:0]  in_byte_offset,
  input  wire logic [2:0]  in_access_size,
  input  wire logic [31:0] in_write_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [31:0] out_read_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  logic [31:0] bar_base_r;
  logic [4:0]  tgt_dev_r;
  logic [2:0]  tgt_fn_r;

  logic           s1_valid_r;
  pcb_pkg::req_t  s1_type_r;
  logic [1:0]     s1_off_r;
  logic [2:0]     s1_size_r;
  logic [31:0]    s1_wdata_r;

  logic           out_valid_r;
  logic [31:0]    out_data_r, out_data_nxt;

  logic [31:0]    latch_r, latch_nxt;
  logic           s2_load, s1_load;
  logic [31:0]    lmask, smask, shifted, hdr_rdata, port_val;
  logic           hit;
  pcb_pkg::hdr_wr_t hdr_wr;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bar_base_r <= '0;
      tgt_dev_r  <= '0;
      tgt_fn_r   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pcb_pkg::CFG_BAR_BASE: bar_base_r <= cfg_data;
        pcb_pkg::CFG_TGT_DEV:  tgt_dev_r  <= cfg_data[4:0];
        pcb_pkg::CFG_TGT_FN:   tgt_fn_r   <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // handshake between the two stages
  assign s2_load  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s2_load;
  assign s1_load  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_type_r  <= pcb_pkg::req_t'(in_req_type);
      s1_off_r   <= in_byte_offset;
      s1_size_r  <= in_access_size;
      s1_wdata_r <= in_write_data;
    end
  end

  assign lmask   = pcb_pkg::lane_mask(s1_off_r, s1_size_r);
  assign smask   = pcb_pkg::size_mask(s1_size_r);
  assign shifted = s1_wdata_r << {s1_off_r, 3'b000};

  assign hit = latch_r[pcb_pkg::LATCH_ENABLE_BIT] && (latch_r[23:16] == 8'h00)
            && (latch_r[15:11] == tgt_dev_r) && (latch_r[10:8] == tgt_fn_r);

  assign hdr_wr.en   = s2_load && (s1_type_r == pcb_pkg::REQ_DATA_WR) && hit && (|lmask);
  assign hdr_wr.idx  = latch_r[7:2];
  assign hdr_wr.data = shifted;
  assign hdr_wr.mask = lmask;

  pcb_hdr #(
    .BAR_SIZE_LOG2 (BAR_SIZE_LOG2)
  ) u_hdr (
    .clk      (clk),
    .rst_n    (rst_n),
    .bar_base (bar_base_r),
    .rd_idx   (latch_r[7:2]),
    .rd_data  (hdr_rdata),
    .wr       (hdr_wr)
  );

  always_comb begin
    latch_nxt = latch_r;
    port_val  = '0;
    unique case (s1_type_r)
      pcb_pkg::REQ_ADDR_RD: port_val = latch_r;
      pcb_pkg::REQ_ADDR_WR: latch_nxt = (latch_r & ~lmask) | (shifted & lmask);
      pcb_pkg::REQ_DATA_RD: port_val = hit ? hdr_rdata : pcb_pkg::ALL_ONES;
      pcb_pkg::REQ_DATA_WR: port_val = '0;
    endcase
    // writes carry zero, reads take the addressed lanes
    out_data_nxt = (port_val >> {s1_off_r, 3'b000}) & smask;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_r <= '0;
    end else if (s2_load) begin
      latch_r <= latch_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;

endmodule

`default_nettype wire

FILE: tb/sv/tb_pci_config_space_bridge.sv
// self-checking bench for pci_config_space_bridge: directed table, then random
// address/data beat sequences checked against an in-bench header predictor
// depends on pcb_pkg (req_t, register indexes) and the bridge rtl
`timescale 1ns / 100ps

module tb_pci_config_space_bridge;
  import pcb_pkg::*;

  localparam int unsigned BAR_SIZE_LOG2 = 12;
  localparam int PHASE_BEATS = 200;
  localparam int N_PHASES = 6;
  localparam int LONG_HOLD = 400;
  localparam int STALL_LIMIT = 2000;

  // header dword indexes, latch bits 7:2
  localparam logic [5:0] REG_IDS    = 6'h00;
  localparam logic [5:0] REG_CMD    = 6'h01;
  localparam logic [5:0] REG_CLASS  = 6'h02;
  localparam logic [5:0] REG_CACHE  = 6'h03;
  localparam logic [5:0] REG_BAR0   = 6'h04;
  localparam logic [5:0] REG_SUBSYS = 6'h0b;
  localparam logic [5:0] REG_INTR   = 6'h0f;

  localparam logic [31:0] IDS_DWORD   = 32'h0035_1033;
  localparam logic [31:0] CLASS_DWORD = 32'h0c03_1010;
  localparam logic [15:0] STATUS_HALF = 16'h0210;
  localparam logic [31:0] NO_DEVICE   = 32'hffff_ffff;
  localparam logic [31:0] BAR_PROBE   = ~((32'd1 << BAR_SIZE_LOG2) - 32'd1);

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  req_t        in_req_type;
  logic [1:0]  in_byte_offset;
  logic [2:0]  in_access_size;
  logic [31:0] in_write_data;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_read_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  pci_config_space_bridge #(
    .BAR_SIZE_LOG2(BAR_SIZE_LOG2)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_byte_offset (in_byte_offset),
    .in_access_size (in_access_size),
    .in_write_data  (in_write_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_data  (out_read_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // predictor state
  logic [31:0] latch_q;
  logic [15:0] cmd_word_q;
  logic [7:0]  cache_line_q;
  logic [7:0]  lat_timer_q;
  logic [7:0]  int_line_q;
  logic        bar_probe_q;
  logic [31:0] bar_base_q;
  logic [4:0]  tgt_dev_q;
  logic [2:0]  tgt_fn_q;

  logic [31:0] read_data_q[$];

  int  errors;
  int  beats_sent;
  int  hdr_hits;
  int  results_seen;
  int  stall_cycles;
  bit  src_idle_en;
  bit  sink_idle_en;
  bit  held_long;

  typedef struct packed {
    req_t        kind;
    logic [1:0]  off;
    logic [2:0]  size;
    logic [31:0] wdata;
    logic        has_read_data;
    logic [31:0] read_data;
  } dir_row_t;

  // reset config: bar_base 0, device 0, function 0
  dir_row_t dir_table [27] = '{
    '{REQ_ADDR_RD, 2'd0, 3'd4, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{REQ_DATA_RD, 2'd0, 3'd4, 32'h0000_0000, 1'b1, 32'hffff_ffff},
    '{REQ_ADDR_WR, 2'd0, 3'd4, 32'h8000_0000, 1'b1, 32'h0000_0000},
    '{REQ_DATA_RD, 2'd0, 3'd4, 32'h0000_0000, 1'b1, 32'h0035_1033},
    '{REQ_ADDR_WR, 2'd0, 3'd1, 32'h0000_0004, 1'b1, 32'h0000_0000},
    '{REQ_DATA_WR, 2'd0, 3'd2, 32'h0000_ffff, 1'b1, 32'h0000_0000},
    '{REQ_DATA_RD, 2'd0, 3'd4, 32'h0000_0000, 1'b1, 32'h0210_ffff},
    '{REQ_DATA_WR, 2'd1, 3'd1, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{REQ_DATA_RD, 2'd2, 3'd4, 32'h0000_0000, 1'b0, 32'h0000_0000},
    '{REQ_ADDR_WR, 2'd0, 3'd1, 32'h0000_0010, 1'b1, 32'h0000_0000},
    '{REQ_DATA_WR, 2'd0, 3'd4, 32'hffff_ffff, 1'b1, 32'h0000_0000},
    '{REQ_DATA_RD, 2'd0, 3'd4, 32'h0000_0000, 1'b1, 32'hffff_f000},
    '{REQ_DATA_WR, 2'd2, 3'd2, 32'h0000_ffff, 1'b0, 32'h0000_0000},
    '{REQ_DATA_WR, 2'd0, 3'd4, 32'h1234_5678, 1'b1, 32'h0000_0000},
    '{REQ_DATA_RD, 2'd0, 3'd4, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{REQ_ADDR_WR, 2'd0, 3'd1, 32'h0000_003c, 1'b1, 32'h0000_0000},
    '{REQ_DATA_RD, 2'd0, 3'd4, 32'h0000_0000, 1'b1, 32'h0000_01ff},
    // size 4 at lane 3 only reaches lane 3, interrupt line keeps its value
    '{REQ_DATA_WR, 2'd3, 3'd4, 32'h0000_00aa, 1'b0, 32'h0000_0000},
    '{REQ_DATA_RD, 2'd1, 3'd2, 32'h0000_0000, 1'b0, 32'h0000_0000},
    '{REQ_DATA_RD, 2'd0, 3'd0, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{REQ_ADDR_RD, 2'd0, 3'd7, 32'h0000_0000, 1'b1, 32'h8000_003c},
    '{REQ_ADDR_WR, 2'd2, 3'd1, 32'h0000_0001, 1'b1, 32'h0000_0000},
    '{REQ_DATA_RD, 2'd0, 3'd4, 32'h0000_0000, 1'b1, 32'hffff_ffff},
    // reserved latch bits set, decode must ignore them
    '{REQ_ADDR_WR, 2'd0, 3'd4, 32'hff00_000f, 1'b1, 32'h0000_0000},
    '{REQ_DATA_WR, 2'd1, 3'd1, 32'h0000_0040, 1'b1, 32'h0000_0000},
    '{REQ_DATA_RD, 2'd0, 3'd4, 32'h0000_0000, 1'b0, 32'h0000_0000},
    '{REQ_ADDR_RD, 2'd3, 3'd1, 32'h0000_0000, 1'b1, 32'h0000_00ff}
  };

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [31:0] byte_span(input logic [2:0] size);
    logic [5:0] nbits;
    nbits = (size > 3'd4) ? 6'd32 : {size, 3'b000};
    byte_span = 32'((64'd1 << nbits) - 64'd1);
  endfunction

  function automatic logic target_hit();
    target_hit = latch_q[31] && (latch_q[23:16] == 8'h00) &&
                 (latch_q[15:11] == tgt_dev_q) && (latch_q[10:8] == tgt_fn_q);
  endfunction

  function automatic logic [31:0] header_dword(input logic [5:0] idx);
    case (idx)
      REG_IDS, REG_SUBSYS: header_dword = IDS_DWORD;
      REG_CMD:             header_dword = {STATUS_HALF, cmd_word_q};
      REG_CLASS:           header_dword = CLASS_DWORD;
      REG_CACHE:           header_dword = {16'h0000, lat_timer_q, cache_line_q};
      REG_BAR0:            header_dword = bar_probe_q ? BAR_PROBE : bar_base_q;
      REG_INTR:            header_dword = {16'h0000, 8'h01, int_line_q};
      default:             header_dword = 32'h0000_0000;
    endcase
  endfunction

  // one beat through the bridge: updates the shadow header, returns read_data
  function automatic logic [31:0] predict_read_data(input req_t kind, input logic [1:0] off,
                                                    input logic [2:0] size,
                                                    input logic [31:0] wdata);
    logic [4:0]  sh;
    logic [31:0] span;
    logic [31:0] lanes;
    logic [31:0] moved;
    logic [31:0] dword;
    sh = {off, 3'b000};
    span = byte_span(size);
    lanes = span << sh;
    moved = wdata << sh;
    predict_read_data = 32'h0000_0000;
    case (kind)
      REQ_ADDR_RD: predict_read_data = (latch_q >> sh) & span;
      REQ_ADDR_WR: latch_q = (latch_q & ~lanes) | (moved & lanes);
      REQ_DATA_RD: begin
        if (target_hit()) hdr_hits++;
        dword = target_hit() ? header_dword(latch_q[7:2]) : NO_DEVICE;
        predict_read_data = (dword >> sh) & span;
      end
      REQ_DATA_WR: begin
        if (lanes != 32'h0 && target_hit()) begin
          hdr_hits++;
          case (latch_q[7:2])
            REG_CMD: cmd_word_q = (cmd_word_q & ~lanes[15:0]) | (moved[15:0] & lanes[15:0]);
            REG_CACHE: begin
              if (lanes[7:0] != 8'h00) cache_line_q = moved[7:0];
              if (lanes[15:8] != 8'h00) lat_timer_q = moved[15:8];
            end
            REG_BAR0: bar_probe_q = &(moved | ~lanes);
            REG_INTR: if (lanes[7:0] != 8'h00) int_line_q = moved[7:0];
            default: ;
          endcase
        end
      end
    endcase
  endfunction

  // leaves in_valid high after the beat goes through
  task automatic send_beat(input req_t kind, input logic [1:0] off, input logic [2:0] size,
                           input logic [31:0] wdata, input logic has_val,
                           input logic [31:0] val);
    logic [31:0] rd;
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= kind;
    in_byte_offset <= off;
    in_access_size <= size;
    in_write_data  <= wdata;
    do @(posedge clk); while (!in_ready);
    rd = predict_read_data(kind, off, size, wdata);
    read_data_q.push_back(has_val ? val : rd);
    beats_sent++;
  endtask

  task automatic drain_results();
    while (read_data_q.size() != 0) @(posedge clk);
  endtask

  // cfg_valid stays high across back-to-back register writes
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_BAR_BASE: bar_base_q = val;
      CFG_TGT_DEV:  tgt_dev_q = val[4:0];
      CFG_TGT_FN:   tgt_fn_q = val[2:0];
      default: ;
    endcase
  endtask

  task automatic load_target(input logic [31:0] base, input logic [31:0] dev,
                             input logic [31:0] fn);
    drain_results();
    repeat (4) @(posedge clk);
    write_reg(CFG_BAR_BASE, base);
    write_reg(CFG_TGT_DEV, dev);
    write_reg(CFG_TGT_FN, fn);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random_phase(input int n_beats);
    int          sent;
    int          n_data;
    int          k;
    int          pick;
    logic [5:0]  reg_sel;
    logic [31:0] addr;
    logic [2:0]  size;
    req_t        kind;
    sent = 0;
    while (sent < n_beats) begin
      if ($urandom_range(0, 9) < 7) begin
        // point the latch at the target (sometimes with one decode field spoiled), then one to four data beats
        if ($urandom_range(0, 3) != 0) begin
          case ($urandom_range(0, 6))
            0: reg_sel = REG_IDS;
            1: reg_sel = REG_CMD;
            2: reg_sel = REG_CLASS;
            3: reg_sel = REG_CACHE;
            4: reg_sel = REG_BAR0;
            5: reg_sel = REG_SUBSYS;
            default: reg_sel = REG_INTR;
          endcase
        end else begin
          reg_sel = 6'($urandom);
        end
        addr = {1'b1, 7'($urandom), 8'h00, tgt_dev_q, tgt_fn_q, reg_sel, 2'($urandom)};
        case ($urandom_range(0, 11))
          0: addr[31] = 1'b0;
          1: addr[23:16] = 8'($urandom_range(1, 255));
          2: addr[15:11] = addr[15:11] + 5'($urandom_range(1, 31));
          3: addr[10:8] = addr[10:8] + 3'($urandom_range(1, 7));
          default: ;
        endcase
        send_beat(REQ_ADDR_WR, 2'd0, 3'd4, addr, 1'b0, 32'h0);
        n_data = $urandom_range(1, 4);
        for (k = 0; k < n_data; k++) begin
          kind = $urandom_range(0, 1) ? REQ_DATA_WR : REQ_DATA_RD;
          pick = $urandom_range(0, 9);
          size = (pick < 3) ? 3'd1 : (pick < 5) ? 3'd2 : (pick < 8) ? 3'd4 :
                 3'($urandom_range(0, 7));
          send_beat(kind, 2'($urandom), size,
                    ($urandom_range(0, 3) == 0) ? NO_DEVICE : $urandom, 1'b0, 32'h0);
        end
        sent += n_data + 1;
      end else begin
        send_beat(req_t'($urandom_range(0, 3)), 2'($urandom), 3'($urandom_range(0, 7)),
                  $urandom, 1'b0, 32'h0);
        sent++;
      end
    end
  endtask

  // result side: compare every beat with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (read_data_q.size() == 0) begin
        $display("%0t: read_data beat with nothing expected, expected none, got %08h",
                 $time, out_read_data);
        errors++;
      end else begin
        if (out_read_data !== read_data_q[0]) begin
          $display("%0t: read_data mismatch, expected %08h, got %08h",
                   $time, read_data_q[0], out_read_data);
          errors++;
        end
        void'(read_data_q.pop_front());
      end
    end
  end

  // result back-pressure: short random stalls plus one long hold
  initial begin
    out_ready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (!held_long && results_seen >= 400) begin
        held_long = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_ready <= 1'b1;
      end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    int r;
    int ph;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_req_type    <= REQ_ADDR_RD;
    in_byte_offset <= 2'd0;
    in_access_size <= 3'd0;
    in_write_data  <= 32'h0;
    cfg_valid      <= 1'b0;
    cfg_index      <= CFG_BAR_BASE;
    cfg_data       <= 32'h0;
    latch_q      = 32'h0;
    cmd_word_q   = 16'h0;
    cache_line_q = 8'h00;
    lat_timer_q  = 8'h00;
    int_line_q   = 8'hff;
    bar_probe_q  = 1'b0;
    bar_base_q   = 32'h0;
    tgt_dev_q    = 5'd0;
    tgt_fn_q     = 3'd0;
    errors       = 0;
    beats_sent   = 0;
    hdr_hits     = 0;
    results_seen = 0;
    stall_cycles = 0;
    held_long    = 1'b0;
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (r = 0; r < $size(dir_table); r++) begin
      send_beat(dir_table[r].kind, dir_table[r].off, dir_table[r].size, dir_table[r].wdata,
                dir_table[r].has_read_data, dir_table[r].read_data);
    end
    in_valid <= 1'b0;

    for (ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: load_target(32'h0, 32'd0, 32'd0);
        1: load_target(32'hffff_ffff, 32'd31, 32'd7);
        default: load_target($urandom, $urandom, $urandom);
      endcase
      if (ph == N_PHASES - 1) begin
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
      end
      run_random_phase(PHASE_BEATS);
      in_valid <= 1'b0;
    end

    drain_results();
    repeat (4) @(posedge clk);
    $display("covered %0d beats over %0d target settings, %0d data beats decoded to the header",
             beats_sent, N_PHASES + 1, hdr_hits);
    $display("%0d results compared, with one %0d-cycle result hold", results_seen, LONG_HOLD);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: pci_config_space_bridge.f
hdl/pcb_pkg.sv
hdl/pcb_hdr.sv
hdl/pci_config_space_bridge.sv
tb/sv/tb_pci_config_space_bridge.sv
